### hw/rtl/evdec_pkg.sv
// Package for the digitizer event word decoder.
// Holds the word and hit payload types, the configuration bundle and the codes.
// No dependencies.
`timescale 1ns / 1ps

package evdec_pkg;

  // Words gathered into one hit; all but the last are held until decode.
  localparam int WORDS_PER_HIT = 5;
  localparam int HELD_WORDS    = WORDS_PER_HIT - 1;
  localparam int POS_W         = $clog2(WORDS_PER_HIT);
  localparam int HELD_IDX_W    = $clog2(HELD_WORDS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_HIT - 1);

  localparam int TS_W   = 56;
  localparam int CNT_W  = 32;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  // Hit layouts. Code 3 is decoded like the wide timestamp layout.
  localparam logic [1:0] FMT_TS56 = 2'd0;
  localparam logic [1:0] FMT_CH5  = 2'd1;
  localparam logic [1:0] FMT_CH4  = 2'd2;

  // Register indexes (byte address / 8).
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_MODULE = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;

  localparam logic [TS_W-1:0] TOL_RESET = TS_W'(100000);

  typedef struct packed {
    logic [15:0] raw_word;
    logic        start_of_file;
  } word_t;

  typedef struct packed {
    logic [TS_W-1:0]  timestamp;
    logic [3:0]       module_id;
    logic [4:0]       channel;
    logic [13:0]      adc_value;
    logic             out_of_order;
    logic [CNT_W-1:0] disorder_total;
  } hit_t;

  typedef struct packed {
    logic [TS_W-1:0] timestamp;
    logic [4:0]      channel;
    logic [13:0]     adc_value;
  } dec_t;

  typedef struct packed {
    logic [1:0]      format_select;
    logic [3:0]      module_number;
    logic [TS_W-1:0] time_margin;
  } cfg_t;

  typedef logic [WORDS_PER_HIT-1:0][15:0] hit_words_t;

endpackage

### hw/rtl/evdec_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on evdec_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module evdec_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [evdec_pkg::ADDR_W-1:0]  paddr,
  input  logic [evdec_pkg::DATA_W-1:0]  pwdata,
  output logic [evdec_pkg::DATA_W-1:0]  prdata,
  output evdec_pkg::cfg_t               cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[4:3];
  assign wr_en     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_select <= evdec_pkg::FMT_TS56;
      cfg.module_number <= 4'd0;
      cfg.time_margin   <= evdec_pkg::TOL_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        evdec_pkg::REG_FORMAT: cfg.format_select <= pwdata[1:0];
        evdec_pkg::REG_MODULE: cfg.module_number <= pwdata[3:0];
        evdec_pkg::REG_TOL:    cfg.time_margin   <= pwdata[evdec_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      evdec_pkg::REG_FORMAT: prdata = {62'd0, cfg.format_select};
      evdec_pkg::REG_MODULE: prdata = {60'd0, cfg.module_number};
      evdec_pkg::REG_TOL:    prdata = {8'd0, cfg.time_margin};
      default:               prdata = '0;
    endcase
  end

endmodule

### hw/rtl/evdec_assemble.sv
// Word intake: byte swap, word position count and the held words of a hit.
// Depends on evdec_pkg; feeds the full hit register to the decoder.
`timescale 1ns / 1ps

module evdec_assemble (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    word_valid,
  input  evdec_pkg::word_t        word_data,
  output logic                    hit_valid,
  output evdec_pkg::hit_words_t   hit_words
);

  logic [evdec_pkg::POS_W-1:0] pos;
  logic [evdec_pkg::POS_W-1:0] pos_eff;
  logic [15:0]                 swapped;
  logic                        accept;
  logic                        last_word;
  logic [15:0]                 held [evdec_pkg::HELD_WORDS];

  assign accept    = word_valid & advance;
  assign pos_eff   = word_data.start_of_file ? '0 : pos;
  assign last_word = (pos_eff == evdec_pkg::LAST_POS);
  assign swapped   = {word_data.raw_word[7:0], word_data.raw_word[15:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      hit_valid <= 1'b0;
    end else if (advance) begin
      hit_valid <= accept & last_word;
      if (accept) begin
        pos <= last_word ? '0 : pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_word) begin
      held[pos_eff[evdec_pkg::HELD_IDX_W-1:0]] <= swapped;
    end
    if (accept && last_word) begin
      for (int i = 0; i < evdec_pkg::HELD_WORDS; i++) begin
        hit_words[i] <= held[i];
      end
      hit_words[evdec_pkg::WORDS_PER_HIT-1] <= swapped;
    end
  end

endmodule

### hw/rtl/evdec_decode.sv
// Layout decode of one gathered hit into timestamp, channel and pulse height.
// Depends on evdec_pkg for the layout codes and the dec_t record.
`timescale 1ns / 1ps

module evdec_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   hit_valid,
  input  evdec_pkg::hit_words_t  hit_words,
  input  logic [1:0]             format_select,
  output logic                   dec_valid,
  output evdec_pkg::dec_t        dec
);

  evdec_pkg::dec_t dec_next;
  logic [47:0]     count48;
  logic [evdec_pkg::TS_W-1:0] count_x10;

  assign count48 = {hit_words[0], hit_words[1], hit_words[2]};
  // Times ten as eight plus two.
  assign count_x10 = {5'd0, count48, 3'd0} + {7'd0, count48, 1'b0};

  always_comb begin
    unique case (format_select)
      evdec_pkg::FMT_CH5: begin
        dec_next.timestamp = count_x10;
        dec_next.channel   = hit_words[3][4:0];
        dec_next.adc_value = {1'b0, hit_words[4][12:0]};
      end
      evdec_pkg::FMT_CH4: begin
        dec_next.timestamp = count_x10;
        dec_next.channel   = {1'b0, hit_words[3][3:0]};
        dec_next.adc_value = hit_words[4][13:0];
      end
      default: begin
        dec_next.timestamp = {hit_words[0], hit_words[1], hit_words[2], hit_words[3][15:8]};
        dec_next.channel   = {2'd0, hit_words[4][15:13]};
        dec_next.adc_value = {1'b0, hit_words[4][12:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (advance) begin
      dec_valid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit_valid) begin
      dec <= dec_next;
    end
  end

endmodule

### hw/rtl/evdec_order.sv
// Time order check against the last good timestamp, disorder count, result register.
// Depends on evdec_pkg for dec_t, hit_t and widths.
`timescale 1ns / 1ps

module evdec_order (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          dec_valid,
  input  evdec_pkg::dec_t               dec,
  input  logic [3:0]                    module_number,
  input  logic [evdec_pkg::TS_W-1:0]    time_margin,
  output logic                          hit_valid,
  output evdec_pkg::hit_t               hit_data
);

  logic [evdec_pkg::TS_W-1:0]  last_time;
  logic [evdec_pkg::TS_W-1:0]  last_time_next;
  logic                        have_last_time;
  logic [evdec_pkg::CNT_W-1:0] disorder_counter;
  logic [evdec_pkg::CNT_W-1:0] disorder_counter_next;
  logic [evdec_pkg::TS_W:0]    ts_plus_tol;
  logic                        flag;
  logic                        take;

  assign take        = advance & dec_valid;
  // One spare bit so the sum never wraps.
  assign ts_plus_tol = {1'b0, dec.timestamp} + {1'b0, time_margin};
  assign flag        = have_last_time & (ts_plus_tol < {1'b0, last_time});

  // A flagged hit lies below the last time, so the last time stays put.
  assign last_time_next        = flag ? last_time : dec.timestamp;
  assign disorder_counter_next = (flag && (disorder_counter != '1)) ?
                                 disorder_counter + 1'b1 : disorder_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid        <= 1'b0;
      last_time        <= '0;
      have_last_time   <= 1'b0;
      disorder_counter <= '0;
    end else if (advance) begin
      hit_valid <= dec_valid;
      if (take) begin
        last_time        <= last_time_next;
        have_last_time   <= have_last_time | ~flag;
        disorder_counter <= disorder_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit_data.timestamp      <= dec.timestamp;
      hit_data.module_id      <= module_number;
      hit_data.channel        <= dec.channel;
      hit_data.adc_value      <= dec.adc_value;
      hit_data.out_of_order   <= flag;
      hit_data.disorder_total <= disorder_counter_next;
    end
  end

endmodule

### hw/rtl/digitizer_event_word_decoder.sv
// Top level of the digitizer event word decoder: intake, decode, order check, registers.
// Depends on evdec_pkg, evdec_cfg, evdec_assemble, evdec_decode and evdec_order.
//
//   channel   direction  handshake                payload
//   word      in         word_valid / word_ready  word_data (evdec_pkg::word_t)
//   hit       out        hit_valid / hit_ready    hit_data  (evdec_pkg::hit_t)
//   config    in         psel / penable / pwrite  paddr, pwdata, prdata (64 bit)
//
// One word is taken every cycle while word_ready is high; every fifth word of a hit yields one result.
// A hit passes three registers (hit, decode, result) in that order, the first
// loaded by the edge that takes its last word. The whole pipeline
// holds while the result register is full and not taken, and word_ready is low then.
// Reset (rst, synchronous) clears the word position, valid flags, last time
// and the disorder count, and loads the register defaults.
`timescale 1ns / 1ps

module digitizer_event_word_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          word_valid,
  output logic                          word_ready,
  input  evdec_pkg::word_t              word_data,
  output logic                          hit_valid,
  input  logic                          hit_ready,
  output evdec_pkg::hit_t               hit_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [evdec_pkg::ADDR_W-1:0]  paddr,
  input  logic [evdec_pkg::DATA_W-1:0]  pwdata,
  output logic [evdec_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  evdec_pkg::cfg_t       cfg;
  evdec_pkg::hit_words_t hit_words;
  evdec_pkg::dec_t       dec;
  logic                  advance;
  logic                  asm_valid;
  logic                  dec_valid;

  assign advance    = ~hit_valid | hit_ready;
  assign word_ready = advance;
  assign pready     = 1'b1;

  evdec_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  evdec_assemble u_assemble (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .word_valid (word_valid),
    .word_data  (word_data),
    .hit_valid  (asm_valid),
    .hit_words  (hit_words)
  );

  evdec_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .hit_valid     (asm_valid),
    .hit_words     (hit_words),
    .format_select (cfg.format_select),
    .dec_valid     (dec_valid),
    .dec           (dec)
  );

  evdec_order u_order (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .dec_valid     (dec_valid),
    .dec           (dec),
    .module_number (cfg.module_number),
    .time_margin   (cfg.time_margin),
    .hit_valid     (hit_valid),
    .hit_data      (hit_data)
  );

endmodule
